>>> rtl/peer_address_node_table_defines.svh
// assertion macros for the peer address node table checker
`ifndef PEER_ADDRESS_NODE_TABLE_DEFINES_SVH
`define PEER_ADDRESS_NODE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PANT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pant check failed");

// next-cycle implication, sampled on clk, off during reset
`define PANT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pant check failed");

`endif

>>> rtl/pant_pkg.sv
// shared types and constants of the peer address node table
package pant_pkg;

    localparam int NODES_DEF = 32;
    localparam int BANS_DEF  = 20;

    // node numbers held in the search token are wide enough for the largest table
    localparam int NODES_MAX  = 256;
    localparam int NODE_IDX_W = $clog2(NODES_MAX);

    localparam logic [31:0] SELF_IP_RST   = 32'h7F00_0001;
    localparam logic [15:0] SELF_PORT_RST = 16'(5000 + 'h1d);

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_SELF_IP   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SELF_PORT = 1'b1;

    typedef logic [NODE_IDX_W-1:0] node_idx_t;

    typedef enum logic [2:0] {
        FUNC_LOOKUP    = 3'd0,
        FUNC_MAKE      = 3'd1,
        FUNC_FREE      = 3'd2,
        FUNC_BAN       = 3'd3,
        FUNC_CLEAR_BAN = 3'd4,
        FUNC_SEND      = 3'd5
    } func_e_t;

    typedef enum logic [3:0] {
        STATUS_KNOWN     = 4'd0,
        STATUS_NEW       = 4'd1,
        STATUS_FULL      = 4'd2,
        STATUS_FREED     = 4'd3,
        STATUS_SELF_KEPT = 4'd4,
        STATUS_BANNED    = 4'd5,
        STATUS_BAN_FULL  = 4'd6,
        STATUS_CLEARED   = 4'd7,
        STATUS_CONN      = 4'd8,
        STATUS_NOT_CONN  = 4'd9
    } status_e_t;

    // item travelling down the node cells
    typedef struct packed {
        logic [31:0] key_ip;
        logic [15:0] key_port;
        logic [4:0]  sel;
        logic        hit;
        node_idx_t   hit_idx;
        logic        hit_ban;
        logic        free_ok;
        node_idx_t   free_idx;
        logic        sel_found;
        node_idx_t   sel_idx;
        logic        sel_used;
        logic        sel_ban;
        logic [31:0] sel_ip;
        logic [15:0] sel_port;
    } node_tok_t;

    // entry update broadcast to the node cells
    typedef struct packed {
        logic        en;
        node_idx_t   idx;
        logic [31:0] ip;
        logic [15:0] port;
        logic        used;
        logic        banned;
    } node_wr_t;

    // item travelling down the ban cells
    typedef struct packed {
        logic [31:0] key_ip;
        logic [15:0] key_port;
        logic        hit;
    } ban_tok_t;

    // ban list write broadcast to the ban cells
    typedef struct packed {
        logic        en;
        logic [31:0] ip;
        logic [15:0] port;
    } ban_wr_t;

endpackage

>>> rtl/pant_node_cell.sv
// one node entry of the table with its stage of the search chain
module pant_node_cell
    import pant_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] self_ip,
    input  logic [15:0] self_port,
    input  node_tok_t   tok_in,
    input  node_wr_t    wr,
    output node_tok_t   tok_out
);

    logic [31:0] e_ip;
    logic [15:0] e_port;
    logic        e_used;
    logic        e_banned;
    node_tok_t   tok_next;
    node_tok_t   tok_reg;

    if (IDX == 0) begin : g_self
        // node 0 is the block itself
        assign e_ip     = self_ip;
        assign e_port   = self_port;
        assign e_used   = 1'b1;
        assign e_banned = 1'b0;
    end
    else begin : g_entry
        logic [31:0] ip_reg;
        logic [15:0] port_reg;
        logic        used_reg;
        logic        banned_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ip_reg     <= '0;
                port_reg   <= '0;
                used_reg   <= 1'b0;
                banned_reg <= 1'b0;
            end
            else if (wr.en && (wr.idx == NODE_IDX_W'(IDX)))
            begin
                ip_reg     <= wr.ip;
                port_reg   <= wr.port;
                used_reg   <= wr.used;
                banned_reg <= wr.banned;
            end
        end

        assign e_ip     = ip_reg;
        assign e_port   = port_reg;
        assign e_used   = used_reg;
        assign e_banned = banned_reg;
    end

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.hit && e_used && (e_ip == tok_in.key_ip) && (e_port == tok_in.key_port))
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = NODE_IDX_W'(IDX);
            tok_next.hit_ban = e_banned;
        end
        if (!tok_in.free_ok && !e_used)
        begin
            tok_next.free_ok  = 1'b1;
            tok_next.free_idx = NODE_IDX_W'(IDX);
        end
        if (int'(tok_in.sel) == IDX)
        begin
            tok_next.sel_found = 1'b1;
            tok_next.sel_idx   = NODE_IDX_W'(IDX);
            tok_next.sel_used  = e_used;
            tok_next.sel_ban   = e_banned;
            tok_next.sel_ip    = e_ip;
            tok_next.sel_port  = e_port;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/pant_ban_cell.sv
// one ban list entry with its stage of the ban check chain
module pant_ban_cell
    import pant_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  logic [CNT_W-1:0] ban_count,
    input  ban_tok_t         tok_in,
    input  ban_wr_t          wr,
    output ban_tok_t         tok_out
);

    logic [31:0] ip_reg;
    logic [15:0] port_reg;
    ban_tok_t    tok_next;
    ban_tok_t    tok_reg;

    // contents undefined until written, only entries below the count are looked at
    always_ff @(posedge clk)
    begin
        if (wr.en && (int'(ban_count) == IDX))
        begin
            ip_reg   <= wr.ip;
            port_reg <= wr.port;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if ((IDX < int'(ban_count)) && (ip_reg == tok_in.key_ip)
            && (port_reg == tok_in.key_port))
        begin
            tok_next.hit = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/peer_address_node_table.sv
// top level of the peer address node table
//
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    func, peer_ip, peer_port, node_sel
//  rsp       out        rsp_valid/rsp_ready    status, node_out, is_banned, out_ip, out_port
//  cfg       in         cfg_wr_en              cfg_addr, cfg_wdata
//
//  an item is held in the launch register while its search token walks one node cell and
//  one ban cell per cycle, both chains side by side
//  reset puts every node but node 0 free, clears ban marks and empties the ban list
//  a waiting result is held in the output register; the next item is taken meanwhile
//  and only its commit cycle waits for the output register to empty
module peer_address_node_table
    import pant_pkg::*;
#(
    parameter int NODES = NODES_DEF,
    parameter int BANS  = BANS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [2:0]            func,
    input  logic [31:0]           peer_ip,
    input  logic [15:0]           peer_port,
    input  logic [4:0]            node_sel,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [3:0]            status,
    output logic [4:0]            node_out,
    output logic                  is_banned,
    output logic [31:0]           out_ip,
    output logic [15:0]           out_port
);

    localparam int RUN_LEN = (NODES > BANS) ? NODES : BANS;
    localparam int RUN_W   = $clog2(RUN_LEN);
    localparam int CNT_W   = $clog2(BANS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_e_t;

    state_e_t         st_reg, st_next;
    logic [RUN_W-1:0] run_cnt_reg, run_cnt_next;
    logic [31:0]      self_ip_reg;
    logic [15:0]      self_port_reg;
    logic [CNT_W-1:0] ban_count_reg, ban_count_next;
    func_e_t          func_reg;
    node_tok_t        launch_reg;

    logic             req_fire;
    logic             done_fire;
    logic             rsp_valid_reg, rsp_valid_next;

    node_tok_t        node_chain [NODES+1];
    ban_tok_t         ban_chain  [BANS+1];
    node_tok_t        nres;
    logic             ban_hit;
    node_wr_t         node_wr;
    ban_wr_t          ban_wr;

    status_e_t        r_status;
    logic [4:0]       r_node;
    logic             r_ban;
    logic [31:0]      r_ip;
    logic [15:0]      r_port;

    status_e_t        status_reg;
    logic [4:0]       node_out_reg;
    logic             is_banned_reg;
    logic [31:0]      out_ip_reg;
    logic [15:0]      out_port_reg;

    assign req_ready = (st_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign done_fire = (st_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_ip_reg   <= SELF_IP_RST;
            self_port_reg <= SELF_PORT_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_addr == REG_SELF_IP)
            begin
                self_ip_reg <= cfg_wdata;
            end
            if (cfg_addr == REG_SELF_PORT)
            begin
                self_port_reg <= cfg_wdata[15:0];
            end
        end
    end

    // launch token, held for the whole run
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg   <= func_e_t'(func);
            launch_reg <= '{key_ip: peer_ip, key_port: peer_port, sel: node_sel,
                            default: '0};
        end
    end

    assign node_chain[0] = launch_reg;
    assign ban_chain[0]  = '{key_ip: launch_reg.key_ip, key_port: launch_reg.key_port,
                             hit: 1'b0};

    for (genvar i = 0; i < NODES; i++)
    begin : g_node
        pant_node_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .self_ip   (self_ip_reg),
            .self_port (self_port_reg),
            .tok_in    (node_chain[i]),
            .wr        (node_wr),
            .tok_out   (node_chain[i+1])
        );
    end

    for (genvar i = 0; i < BANS; i++)
    begin : g_ban
        pant_ban_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ban_count (ban_count_reg),
            .tok_in    (ban_chain[i]),
            .wr        (ban_wr),
            .tok_out   (ban_chain[i+1])
        );
    end

    assign nres    = node_chain[NODES];
    assign ban_hit = ban_chain[BANS].hit;

    // result and table updates at the end of the run
    always_comb
    begin
        r_status       = STATUS_NOT_CONN;
        r_node         = '0;
        r_ban          = 1'b0;
        r_ip           = '0;
        r_port         = '0;
        node_wr        = '0;
        ban_wr         = '0;
        ban_count_next = ban_count_reg;
        unique case (func_reg)
            FUNC_LOOKUP:
            begin
                if (nres.hit)
                begin
                    r_status = STATUS_KNOWN;
                    r_node   = 5'(nres.hit_idx);
                    r_ban    = nres.hit_ban;
                end
                else if (!nres.free_ok)
                begin
                    r_status = STATUS_FULL;
                end
                else
                begin
                    r_status       = STATUS_NEW;
                    r_node         = 5'(nres.free_idx);
                    r_ban          = ban_hit;
                    node_wr.en     = done_fire;
                    node_wr.idx    = nres.free_idx;
                    node_wr.ip     = launch_reg.key_ip;
                    node_wr.port   = launch_reg.key_port;
                    node_wr.used   = 1'b1;
                    node_wr.banned = ban_hit;
                end
            end
            FUNC_MAKE:
            begin
                if (!nres.free_ok)
                begin
                    r_status = STATUS_FULL;
                end
                else
                begin
                    r_status     = STATUS_NEW;
                    r_node       = 5'(nres.free_idx);
                    node_wr.en   = done_fire;
                    node_wr.idx  = nres.free_idx;
                    node_wr.ip   = launch_reg.key_ip;
                    node_wr.port = launch_reg.key_port;
                    node_wr.used = 1'b1;
                end
            end
            FUNC_FREE:
            begin
                r_node = launch_reg.sel;
                if (launch_reg.sel == '0)
                begin
                    r_status = STATUS_SELF_KEPT;
                    r_ban    = nres.sel_ban;
                end
                else
                begin
                    // freed entry goes back to all zero
                    r_status    = STATUS_FREED;
                    node_wr.en  = done_fire && nres.sel_found;
                    node_wr.idx = nres.sel_idx;
                end
            end
            FUNC_BAN:
            begin
                r_node = launch_reg.sel;
                r_ban  = nres.sel_ban;
                if (ban_count_reg == CNT_W'(BANS))
                begin
                    r_status = STATUS_BAN_FULL;
                end
                else
                begin
                    r_status       = STATUS_BANNED;
                    ban_wr.en      = done_fire;
                    ban_wr.ip      = nres.sel_ip;
                    ban_wr.port    = nres.sel_port;
                    ban_count_next = ban_count_reg + CNT_W'(1);
                end
            end
            FUNC_CLEAR_BAN:
            begin
                r_status       = STATUS_CLEARED;
                ban_count_next = '0;
            end
            FUNC_SEND:
            begin
                r_node = launch_reg.sel;
                r_ban  = nres.sel_ban;
                if (nres.sel_used)
                begin
                    r_status = STATUS_CONN;
                    r_ip     = nres.sel_ip;
                    r_port   = nres.sel_port;
                end
            end
            default:
            begin
                r_status = STATUS_NOT_CONN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ban_count_reg <= '0;
        end
        else if (done_fire)
        begin
            ban_count_reg <= ban_count_next;
        end
    end

    // sequencer
    always_comb
    begin
        st_next      = st_reg;
        run_cnt_next = run_cnt_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                run_cnt_next = '0;
                if (req_fire)
                begin
                    st_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                run_cnt_next = run_cnt_reg + RUN_W'(1);
                if (run_cnt_reg == RUN_W'(RUN_LEN - 1))
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            run_cnt_reg <= '0;
        end
        else
        begin
            st_reg      <= st_next;
            run_cnt_reg <= run_cnt_next;
        end
    end

    // output register
    always_comb
    begin
        priority if (done_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            status_reg    <= r_status;
            node_out_reg  <= r_node;
            is_banned_reg <= r_ban;
            out_ip_reg    <= r_ip;
            out_port_reg  <= r_port;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign node_out  = node_out_reg;
    assign is_banned = is_banned_reg;
    assign out_ip    = out_ip_reg;
    assign out_port  = out_port_reg;

endmodule

>>> rtl/pant_checker.sv
// port checker for the peer address node table, bound to the top level
`include "peer_address_node_table_defines.svh"

module pant_checker
    import pant_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [3:0]  status,
    input logic [4:0]  node_out,
    input logic        is_banned,
    input logic [31:0] out_ip,
    input logic [15:0] out_port
);

    // a stalled result keeps its status, node number and ip address
    `PANT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(status) && $stable(node_out) && $stable(out_ip))

    // one item at a time: no second item right after an accepted one
    `PANT_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

    // a fresh result comes together with the block turning ready again
    `PANT_ASSERT_SAME(a_rsp_with_ready, $rose(rsp_valid), req_ready)

    // full and cleared results carry no node
    `PANT_ASSERT_SAME(a_no_node,
        rsp_valid && (status == STATUS_FULL || status == STATUS_CLEARED),
        node_out == 5'd0 && !is_banned && out_ip == 32'd0)

    // only a connected send query shows an address
    `PANT_ASSERT_SAME(a_addr_only_conn, rsp_valid && status != STATUS_CONN,
        out_ip == 32'd0 && out_port == 16'd0)

endmodule

bind peer_address_node_table pant_checker u_pant_checker (.*);
